// ===== sv/mdt_pkg.sv =====
// Shared types and constants for the city-block distance transform.
package mdt_pkg;

  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIST_W    = 8;

  localparam logic [DIST_W-1:0] FAR_DIST = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd1;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_FETCH,
    TOP_SWEEP
  } ctl_state_e;

  typedef enum logic [1:0] {
    SW_IDLE,
    SW_READ,
    SW_WRITE
  } sweep_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_status_t;

endpackage

// ===== sv/mdt_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
module mdt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                         rdata_a_o,
  output logic [WIDTH-1:0]                         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== sv/mdt_sweep.sv =====
// Forward and backward raster sweep engine over the distance memory.
module mdt_sweep #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64,
  localparam int unsigned DEPTH   = MAX_ROWS * MAX_COLS,
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned RDIM_W  = $clog2(MAX_ROWS + 1),
  localparam int unsigned CDIM_W  = $clog2(MAX_COLS + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [RDIM_W-1:0]          rows_i,
  input  logic [CDIM_W-1:0]          cols_i,
  output mdt_pkg::sweep_status_t     status_o,
  output logic [ADDR_W-1:0]          raddr_a_o,
  output logic [ADDR_W-1:0]          raddr_b_o,
  input  logic [mdt_pkg::DIST_W-1:0] rdata_a_i,
  input  logic [mdt_pkg::DIST_W-1:0] rdata_b_i,
  output logic                       we_o,
  output logic [ADDR_W-1:0]          waddr_o,
  output logic [mdt_pkg::DIST_W-1:0] wdata_o
);

  localparam int unsigned RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  mdt_pkg::sweep_state_e state_q, state_d;
  logic                       bwd_q, bwd_d;
  logic [RIDX_W-1:0]          row_q, row_d;
  logic [CIDX_W-1:0]          col_q, col_d;
  logic [ADDR_W-1:0]          idx_q, idx_d;
  logic [mdt_pkg::DIST_W-1:0] prev_q, prev_d;

  logic                       row_last;
  logic                       col_last;
  logic                       nb_valid;
  logic                       side_valid;
  logic [RIDX_W-1:0]          row_max;
  logic [CIDX_W-1:0]          col_max;
  logic [mdt_pkg::DIST_W-1:0] nb_val;
  logic [mdt_pkg::DIST_W-1:0] side_val;
  logic [mdt_pkg::DIST_W-1:0] min_val;
  logic [mdt_pkg::DIST_W-1:0] cand;
  logic [mdt_pkg::DIST_W-1:0] new_val;
  logic                       finish;

  assign row_max    = RIDX_W'(rows_i - RDIM_W'(1));
  assign col_max    = CIDX_W'(cols_i - CDIM_W'(1));
  assign row_last   = (row_q == row_max);
  assign col_last   = (col_q == col_max);
  assign nb_valid   = bwd_q ? !row_last : (row_q != '0);
  assign side_valid = bwd_q ? !col_last : (col_q != '0);
  assign finish     = bwd_q && (row_q == '0) && (col_q == '0);

  assign raddr_a_o = idx_q;
  always_comb begin
    if (!nb_valid) begin
      raddr_b_o = idx_q;
    end else if (bwd_q) begin
      raddr_b_o = idx_q + ADDR_W'(cols_i);
    end else begin
      raddr_b_o = idx_q - ADDR_W'(cols_i);
    end
  end

  // saturating min-plus-one update
  always_comb begin
    nb_val   = nb_valid ? rdata_b_i : mdt_pkg::FAR_DIST;
    side_val = side_valid ? prev_q : mdt_pkg::FAR_DIST;
    min_val  = (nb_val < side_val) ? nb_val : side_val;
    cand     = (min_val == mdt_pkg::FAR_DIST) ? mdt_pkg::FAR_DIST
                                              : min_val + mdt_pkg::DIST_W'(1);
    if (rdata_a_i == '0) begin
      new_val = '0;
    end else if (bwd_q && (rdata_a_i < cand)) begin
      new_val = rdata_a_i;
    end else begin
      new_val = cand;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdt_pkg::SW_IDLE:  if (start_i) state_d = mdt_pkg::SW_READ;
      mdt_pkg::SW_READ:  state_d = mdt_pkg::SW_WRITE;
      mdt_pkg::SW_WRITE: state_d = finish ? mdt_pkg::SW_IDLE : mdt_pkg::SW_READ;
      default:           state_d = mdt_pkg::SW_IDLE;
    endcase
  end

  always_comb begin
    bwd_d         = bwd_q;
    row_d         = row_q;
    col_d         = col_q;
    idx_d         = idx_q;
    prev_d        = prev_q;
    we_o          = 1'b0;
    waddr_o       = idx_q;
    wdata_o       = new_val;
    status_o.busy = (state_q != mdt_pkg::SW_IDLE);
    status_o.done = 1'b0;
    unique case (state_q)
      mdt_pkg::SW_IDLE: begin
        if (start_i) begin
          bwd_d = 1'b0;
          row_d = '0;
          col_d = '0;
          idx_d = '0;
        end
      end
      mdt_pkg::SW_READ: begin
      end
      mdt_pkg::SW_WRITE: begin
        we_o   = 1'b1;
        prev_d = new_val;
        if (!bwd_q) begin
          if (col_last && row_last) begin
            bwd_d = 1'b1;
          end else if (col_last) begin
            col_d = '0;
            row_d = row_q + RIDX_W'(1);
            idx_d = idx_q + ADDR_W'(1);
          end else begin
            col_d = col_q + CIDX_W'(1);
            idx_d = idx_q + ADDR_W'(1);
          end
        end else if (finish) begin
          status_o.done = 1'b1;
        end else if (col_q == '0) begin
          col_d = col_max;
          row_d = row_q - RIDX_W'(1);
          idx_d = idx_q - ADDR_W'(1);
        end else begin
          col_d = col_q - CIDX_W'(1);
          idx_d = idx_q - ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdt_pkg::SW_IDLE;
      bwd_q   <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      bwd_q   <= bwd_d;
      row_q   <= row_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

endmodule

// ===== sv/manhattan_distance_transform_top.sv =====
// Top level of the city-block distance transform: load, sweep and readout control.
// Loads are taken while idle; a fetch reads the memory, then registers the result
// at the output before another transaction is taken. The last load of an image
// starts a forward then a backward sweep: per pixel a memory read, then write back.
// Reset clears counters, sizes (64 x 64) and status; memory contents stay undefined.
module manhattan_distance_transform_top #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic                          pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mdt_pkg::DIST_W-1:0]    distance_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mdt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mdt_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned RDIM_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CDIM_W = $clog2(MAX_COLS + 1);

  mdt_pkg::ctl_state_e state_q, state_d;

  logic [mdt_pkg::CFG_W-1:0]  rows_q, rows_d;
  logic [mdt_pkg::CFG_W-1:0]  cols_q, cols_d;
  logic [CNT_W-1:0]           load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0]           read_cnt_q, read_cnt_d;
  logic                       ready_q, ready_d;
  logic                       pend_last_q, pend_last_d;
  logic                       out_valid_q, out_valid_d;
  logic [mdt_pkg::DIST_W-1:0] out_dist_q, out_dist_d;
  logic                       out_last_q, out_last_d;

  logic [RDIM_W-1:0]          rows_eff;
  logic [CDIM_W-1:0]          cols_eff;
  logic [CNT_W-1:0]           total;
  logic                       in_fire;
  logic                       load_fire;
  logic                       fetch_fire;
  logic [CNT_W-1:0]           load_base;
  logic [CNT_W-1:0]           load_next;
  logic                       load_done;
  logic                       read_last;
  logic                       sweep_start;

  mdt_pkg::sweep_status_t     sweep_status;
  logic [ADDR_W-1:0]          sw_raddr_a;
  logic [ADDR_W-1:0]          sw_raddr_b;
  logic                       sw_we;
  logic [ADDR_W-1:0]          sw_waddr;
  logic [mdt_pkg::DIST_W-1:0] sw_wdata;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [mdt_pkg::DIST_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr_a;
  logic [mdt_pkg::DIST_W-1:0] ram_rdata_a;
  logic [mdt_pkg::DIST_W-1:0] ram_rdata_b;

  always_comb begin
    if (rows_q == '0) begin
      rows_eff = RDIM_W'(1);
    end else if (rows_q > mdt_pkg::CFG_W'(MAX_ROWS)) begin
      rows_eff = RDIM_W'(MAX_ROWS);
    end else begin
      rows_eff = RDIM_W'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = CDIM_W'(1);
    end else if (cols_q > mdt_pkg::CFG_W'(MAX_COLS)) begin
      cols_eff = CDIM_W'(MAX_COLS);
    end else begin
      cols_eff = CDIM_W'(cols_q);
    end
  end

  assign total = CNT_W'(rows_eff) * CNT_W'(cols_eff);

  // configuration
  assign cfg_ready_o = 1'b1;
  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == mdt_pkg::REG_IMAGE_ROWS) rows_d = cfg_data_i;
      if (cfg_index_i == mdt_pkg::REG_IMAGE_COLS) cols_d = cfg_data_i;
    end
  end

  assign in_fire     = in_valid_i && !in_stall_o;
  assign load_fire   = in_fire && (mode_i == mdt_pkg::MODE_LOAD);
  assign fetch_fire  = in_fire && (mode_i == mdt_pkg::MODE_FETCH) && ready_q;
  assign load_base   = ready_q ? '0 : load_cnt_q;
  assign load_next   = load_base + CNT_W'(1);
  assign load_done   = (load_next >= total);
  assign read_last   = ((read_cnt_q + CNT_W'(1)) >= total);
  assign sweep_start = load_fire && load_done;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mdt_pkg::TOP_IDLE: begin
        if (sweep_start) begin
          state_d = mdt_pkg::TOP_SWEEP;
        end else if (fetch_fire) begin
          state_d = mdt_pkg::TOP_FETCH;
        end
      end
      mdt_pkg::TOP_FETCH: state_d = mdt_pkg::TOP_IDLE;
      mdt_pkg::TOP_SWEEP: if (sweep_status.done) state_d = mdt_pkg::TOP_IDLE;
      default:            state_d = mdt_pkg::TOP_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o  = 1'b1;
    load_cnt_d  = load_cnt_q;
    read_cnt_d  = read_cnt_q;
    ready_d     = ready_q;
    pend_last_d = pend_last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_dist_d  = out_dist_q;
    out_last_d  = out_last_q;
    ram_raddr_a = read_cnt_q[ADDR_W-1:0];
    ram_we      = 1'b0;
    ram_waddr   = load_base[ADDR_W-1:0];
    ram_wdata   = pixel_i ? mdt_pkg::FAR_DIST : '0;
    unique case (state_q)
      mdt_pkg::TOP_IDLE: begin
        in_stall_o = (mode_i == mdt_pkg::MODE_FETCH) && out_valid_q && out_stall_i;
        if (load_fire) begin
          ram_we     = 1'b1;
          ready_d    = 1'b0;
          read_cnt_d = '0;
          load_cnt_d = load_done ? '0 : load_next;
        end
        if (fetch_fire) begin
          pend_last_d = read_last;
          read_cnt_d  = read_last ? '0 : read_cnt_q + CNT_W'(1);
        end
      end
      mdt_pkg::TOP_FETCH: begin
        out_valid_d = 1'b1;
        out_dist_d  = ram_rdata_a;
        out_last_d  = pend_last_q;
      end
      mdt_pkg::TOP_SWEEP: begin
        ram_raddr_a = sw_raddr_a;
        ram_we      = sw_we;
        ram_waddr   = sw_waddr;
        ram_wdata   = sw_wdata;
        if (sweep_status.done) begin
          ready_d    = 1'b1;
          read_cnt_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  mdt_sweep #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sweep_start),
    .rows_i    (rows_eff),
    .cols_i    (cols_eff),
    .status_o  (sweep_status),
    .raddr_a_o (sw_raddr_a),
    .raddr_b_o (sw_raddr_b),
    .rdata_a_i (ram_rdata_a),
    .rdata_b_i (ram_rdata_b),
    .we_o      (sw_we),
    .waddr_o   (sw_waddr),
    .wdata_o   (sw_wdata)
  );

  mdt_ram #(
    .WIDTH(mdt_pkg::DIST_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (sw_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mdt_pkg::TOP_IDLE;
      rows_q      <= mdt_pkg::CFG_W'(64);
      cols_q      <= mdt_pkg::CFG_W'(64);
      load_cnt_q  <= '0;
      read_cnt_q  <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      cols_q      <= cols_d;
      load_cnt_q  <= load_cnt_d;
      read_cnt_q  <= read_cnt_d;
      ready_q     <= ready_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_last_q <= pend_last_d;
    out_dist_q  <= out_dist_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = out_dist_q;
  assign last_o      = out_last_q;

  a_sweep_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_status.busy |-> in_stall_o)
    else $error("transaction accepted during sweep");

  a_ready_not_sweeping: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_q && sweep_status.busy))
    else $error("result ready while sweep busy");

  a_out_from_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == mdt_pkg::TOP_FETCH))
    else $error("output valid without fetch");

  a_fetch_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mdt_pkg::TOP_FETCH) |-> (!out_valid_q || !out_stall_i))
    else $error("fetch data would overwrite pending output");

endmodule
